[hw/rtl/bcso_pkg.sv]
// shared types and constants for the bridge check / strong orientation unit
// no dependencies
package bcso_pkg;
  localparam int unsigned MaxNodesDefault = 64;
  localparam int unsigned NodeCountReset  = 64;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_SOLVE = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [1:0] ST_ACK    = 2'd0;
  localparam logic [1:0] ST_ORIENT = 2'd1;
  localparam logic [1:0] ST_BRIDGE = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] node_a;
    logic [5:0] node_b;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       directed;
  } rsp_t;
endpackage

[hw/rtl/bcso_if.sv]
// valid/ready channel interfaces for request and response beats
// depends on bcso_pkg
interface bcso_req_if;
  logic              valid;
  logic              ready;
  bcso_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bcso_rsp_if;
  logic              valid;
  logic              ready;
  bcso_pkg::rsp_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/bridge_check_strong_orientation_unit.sv]
// bridge check and strong orientation of an undirected graph, one beat in flight
// read answers from the registered row, add sets the edge in both rows, clear sweeps
// every row, solve walks from node 0 scanning each row bit, resolving each set bit
// and returning to each parent; next beat taken once the held result is accepted
// reset (async, active low) empties the adjacency matrix by a clearing sweep of
// all MAX_NODES rows during which no beat is accepted; node_count resets to 64
module bridge_check_strong_orientation_unit #(
  parameter int unsigned MaxNodes = bcso_pkg::MaxNodesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  bcso_req_if.sink   req,
  bcso_rsp_if.source rsp
);
  import bcso_pkg::*;

  localparam int unsigned AW = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned CW = $clog2(MaxNodes + 1);

  // sequencer codes
  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CLEAR  = 4'd2;
  localparam logic [3:0] S_ADD2   = 4'd3;
  localparam logic [3:0] S_READ   = 4'd4;
  localparam logic [3:0] S_START  = 4'd5;
  localparam logic [3:0] S_FETCH  = 4'd6;
  localparam logic [3:0] S_SCAN   = 4'd7;
  localparam logic [3:0] S_POP    = 4'd8;
  localparam logic [3:0] S_POP2   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;
  localparam logic [3:0] S_ADD    = 4'd11;
  localparam logic [3:0] S_BACK2  = 4'd12;
  localparam logic [3:0] S_RESUME = 4'd13;

  logic [3:0] state_q, state_d;
  logic [6:0] node_count_q;
  logic [CW-1:0] eff_n;

  // adjacency matrix, one row per node, one row write port and one row read port
  logic [MaxNodes-1:0] adj_mem [MaxNodes];
  logic [MaxNodes-1:0] row_q;          // registered row read
  logic                row_we;
  logic [AW-1:0]       row_waddr, row_raddr;
  logic [MaxNodes-1:0] row_wdata;

  // per-node discovery / low link memories
  logic [CW-1:0] disc_mem [MaxNodes];
  logic [CW-1:0] low_mem  [MaxNodes];
  logic [MaxNodes-1:0] visited_q;

  // walk stack: node, parent (with no-parent flag), next index
  logic [AW-1:0] stk_node [MaxNodes];
  logic [AW:0]   stk_par  [MaxNodes];
  logic [CW-1:0] stk_next [MaxNodes];
  logic [CW-1:0] sp_q;                 // stack depth

  // current frame in registers
  logic [AW-1:0] v_q;
  logic [AW:0]   par_q;
  logic [CW-1:0] nx_q;
  logic [CW-1:0] disc_v_q, low_v_q;
  logic [CW-1:0] clk_cnt_q;

  logic [AW-1:0] a_q, b_q;
  logic          a_ok_q, b_ok_q;
  logic [AW:0]   sweep_q;
  logic [CW-1:0] child_low_q;
  rsp_t          rsp_q;
  logic          rsp_valid_q;

  assign eff_n = (node_count_q > 7'(MaxNodes)) ? CW'(MaxNodes) : CW'(node_count_q);
  assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp.valid = rsp_valid_q;
  assign rsp.data  = rsp_q;

  logic acc;
  assign acc = req.valid && req.ready;

  // current scan index within row
  logic [AW-1:0] idx;
  assign idx = nx_q[AW-1:0];
  logic bit_set;
  assign bit_set = row_q[idx];

  always_ff @(posedge clk_i) begin
    if (row_we) adj_mem[row_waddr] <= row_wdata;
    row_q <= adj_mem[row_raddr];
  end

  // control-side updates of per-node and stack memories
  logic          dm_we; logic [AW-1:0] dm_addr; logic [CW-1:0] dm_wd;
  logic          lm_we; logic [AW-1:0] lm_addr; logic [CW-1:0] lm_wd;
  logic          sk_we; logic [AW-1:0] sk_addr;
  logic [AW-1:0] sk_node; logic [AW:0] sk_par; logic [CW-1:0] sk_next;
  logic [CW-1:0] disc_rd_q, low_rd_q;
  logic [AW-1:0] nd_raddr;
  logic [AW-1:0] sk_raddr;
  logic [AW-1:0] sk_rnode_q; logic [AW:0] sk_rpar_q; logic [CW-1:0] sk_rnext_q;

  always_ff @(posedge clk_i) begin
    if (dm_we) disc_mem[dm_addr] <= dm_wd;
    if (lm_we) low_mem[lm_addr] <= lm_wd;
    disc_rd_q <= disc_mem[nd_raddr];
    low_rd_q  <= low_mem[nd_raddr];
    if (sk_we) begin
      stk_node[sk_addr] <= sk_node;
      stk_par[sk_addr]  <= sk_par;
      stk_next[sk_addr] <= sk_next;
    end
    sk_rnode_q <= stk_node[sk_raddr];
    sk_rpar_q  <= stk_par[sk_raddr];
    sk_rnext_q <= stk_next[sk_raddr];
  end

  // next-state / datapath control
  logic [MaxNodes-1:0] vis_d;
  logic [CW-1:0] sp_d, nx_d, disc_v_d, low_v_d, clk_d, child_low_d;
  logic [AW-1:0] v_d, a_d, b_d;
  logic [AW:0]   par_d, sweep_d;
  logic          a_ok_d, b_ok_d, rsp_valid_d;
  rsp_t          rsp_d;

  always_comb begin
    state_d = state_q; vis_d = visited_q; sp_d = sp_q; nx_d = nx_q;
    v_d = v_q; par_d = par_q; disc_v_d = disc_v_q; low_v_d = low_v_q;
    clk_d = clk_cnt_q; a_d = a_q; b_d = b_q; a_ok_d = a_ok_q; b_ok_d = b_ok_q;
    sweep_d = sweep_q; child_low_d = child_low_q;
    rsp_d = rsp_q; rsp_valid_d = rsp_valid_q;
    row_we = 1'b0; row_waddr = v_q; row_wdata = row_q; row_raddr = v_q;
    dm_we = 1'b0; dm_addr = v_q; dm_wd = clk_cnt_q;
    lm_we = 1'b0; lm_addr = v_q; lm_wd = low_v_q;
    sk_we = 1'b0; sk_addr = AW'(sp_q); sk_node = v_q; sk_par = par_q; sk_next = nx_q;
    nd_raddr = idx; sk_raddr = AW'(sp_q - CW'(1));

    if (rsp_valid_q && rsp.ready) rsp_valid_d = 1'b0;

    case (state_q)
      S_INIT, S_CLEAR: begin
        // one row per cycle
        row_we = 1'b1; row_waddr = sweep_q[AW-1:0]; row_wdata = '0;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == (AW+1)'(MaxNodes - 1)) begin
          if (state_q == S_CLEAR) begin
            rsp_d = '{status: ST_ACK, directed: 1'b0}; rsp_valid_d = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          a_d = req.data.node_a[AW-1:0]; b_d = req.data.node_b[AW-1:0];
          a_ok_d = 7'(req.data.node_a) < 7'(eff_n);
          b_ok_d = 7'(req.data.node_b) < 7'(eff_n);
          v_d = req.data.node_a[AW-1:0];
          sweep_d = '0;
          case (req.data.action)
            ACT_CLEAR: state_d = S_CLEAR;
            ACT_ADD:   state_d = S_ADD;
            ACT_SOLVE: state_d = S_START;
            default: begin
              a_ok_d = 32'(req.data.node_a) < MaxNodes;
              b_ok_d = 32'(req.data.node_b) < MaxNodes;
              state_d = S_READ;
            end
          endcase
          row_raddr = req.data.node_a[AW-1:0];
        end
      end
      S_READ: begin
        rsp_d = '{status: ST_ACK, directed: a_ok_q && b_ok_q && row_q[b_q]};
        rsp_valid_d = 1'b1; state_d = S_IDLE;
      end
      S_ADD: begin
        // row a is in row_q; set bit b, fetch row b
        if (a_ok_q && b_ok_q) begin
          row_we = 1'b1; row_waddr = a_q; row_wdata = row_q | (MaxNodes'(1) << b_q);
        end
        row_raddr = b_q; state_d = S_ADD2;
      end
      S_ADD2: begin
        state_d = S_BACK2;
        row_raddr = b_q;
      end
      S_BACK2: begin
        if (a_ok_q && b_ok_q) begin
          row_we = 1'b1; row_waddr = b_q; row_wdata = row_q | (MaxNodes'(1) << a_q);
        end
        rsp_d = '{status: ST_ACK, directed: 1'b0}; rsp_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      S_START: begin
        // visit node 0
        vis_d = '0; vis_d[0] = 1'b1;
        v_d = '0; par_d = (AW+1)'(MaxNodes); nx_d = '0;
        disc_v_d = '0; low_v_d = '0; clk_d = CW'(1); sp_d = CW'(1);
        dm_we = 1'b1; dm_addr = '0; dm_wd = '0;
        row_raddr = '0; state_d = S_FETCH;
      end
      S_FETCH: begin
        // row of v arriving; discovery/low of idx readable next
        row_raddr = v_q; state_d = S_SCAN;
      end
      S_SCAN: begin
        // one neighbor index per cycle while its bit is clear (with one lookahead read of its times)
        nd_raddr = idx;
        if (nx_q >= eff_n) begin
          lm_we = 1'b1; lm_addr = v_q; lm_wd = low_v_q;
          sp_d = sp_q - CW'(1); child_low_d = low_v_q;
          if (sp_q == CW'(1)) begin
            rsp_d = '{status: ST_ORIENT, directed: 1'b0}; rsp_valid_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            sk_raddr = AW'(sp_q - CW'(2)); state_d = S_POP;
          end
        end else if (!bit_set) begin
          nx_d = nx_q + 1'b1;
        end else begin
          state_d = S_DONE; // resolve this neighbor after its times are read
        end
      end
      S_DONE: begin
        // neighbor idx has an edge; remove reverse direction
        nd_raddr = idx;
        row_raddr = idx; state_d = S_POP2;
      end
      S_POP2: begin
        // row_q holds row idx now; clear bit v
        row_we = 1'b1; row_waddr = idx; row_wdata = row_q & ~(MaxNodes'(1) << v_q);
        nx_d = nx_q + 1'b1;
        if ({1'b0, idx} == par_q) begin
          row_raddr = v_q; state_d = S_FETCH;
        end else if (!visited_q[idx]) begin
          // push current frame and its low link, then descend
          sk_we = 1'b1; sk_addr = AW'(sp_q - CW'(1));
          sk_node = v_q; sk_par = par_q; sk_next = nx_q + 1'b1;
          lm_we = 1'b1;
          vis_d[idx] = 1'b1;
          dm_we = 1'b1; dm_addr = idx; dm_wd = clk_cnt_q;
          sp_d = sp_q + 1'b1;
          par_d = {1'b0, v_q}; v_d = idx; nx_d = '0;
          disc_v_d = clk_cnt_q; low_v_d = clk_cnt_q; clk_d = clk_cnt_q + 1'b1;
          row_raddr = idx; state_d = S_FETCH;
        end else begin
          // a self loop never signals a bridge
          if (disc_rd_q < low_v_q) low_v_d = disc_rd_q;
          if ((idx != v_q) && (disc_v_q < low_rd_q)) begin
            rsp_d = '{status: ST_BRIDGE, directed: 1'b0}; rsp_valid_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            row_raddr = v_q; state_d = S_FETCH;
          end
        end
      end
      S_POP: begin
        // parent frame read from stack; fetch its times
        nd_raddr = sk_rnode_q;
        v_d = sk_rnode_q; par_d = sk_rpar_q; nx_d = sk_rnext_q;
        state_d = S_RESUME;
      end
      S_RESUME: begin
        // parent times available
        disc_v_d = disc_rd_q;
        low_v_d = (child_low_q < low_rd_q) ? child_low_q : low_rd_q;
        if (disc_rd_q < child_low_q) begin
          rsp_d = '{status: ST_BRIDGE, directed: 1'b0}; rsp_valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          row_raddr = v_q; state_d = S_FETCH;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; node_count_q <= 7'(NodeCountReset);
      sweep_q <= '0; rsp_valid_q <= 1'b0; visited_q <= '0; sp_q <= '0;
      clk_cnt_q <= '0;
    end else begin
      state_q <= state_d; sweep_q <= sweep_d; rsp_valid_q <= rsp_valid_d;
      visited_q <= vis_d; sp_q <= sp_d; clk_cnt_q <= clk_d;
      if (cfg_we_i) node_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; par_q <= par_d; nx_q <= nx_d; disc_v_q <= disc_v_d;
    low_v_q <= low_v_d; a_q <= a_d; b_q <= b_d; a_ok_q <= a_ok_d; b_ok_q <= b_ok_d;
    child_low_q <= child_low_d; rsp_q <= rsp_d;
  end
endmodule

[hw/rtl/bcso_checker.sv]
// port-level checks for the bridge check unit, bound to the top level
// depends on bcso_pkg; bound into bridge_check_strong_orientation_unit
module bcso_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic [1:0] rsp_status_i,
  input logic rsp_directed_i
);
  import bcso_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i))
    else $error("stalled beat changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i)
    else $error("accepting while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_status_i <= ST_BRIDGE)
    else $error("bad status");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_directed_i |-> rsp_status_i == ST_ACK)
    else $error("directed flag on solve");
endmodule

bind bridge_check_strong_orientation_unit bcso_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid_i(req.valid), .req_ready_i(req.ready),
  .rsp_valid_i(rsp.valid), .rsp_ready_i(rsp.ready), .rsp_status_i(rsp.data.status),
  .rsp_directed_i(rsp.data.directed)
);
